// ===== rtl/core/image_min_max_mean_stddev_unit_defines.svh =====
// assertion macros for the image statistics unit
`ifndef IMAGE_MIN_MAX_MEAN_STDDEV_UNIT_DEFINES_SVH
`define IMAGE_MIN_MAX_MEAN_STDDEV_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define IMMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define IMMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/imms_pkg.sv =====
// shared types and constants of the image statistics unit
`default_nettype none

package imms_pkg;

  // field and accumulator widths
  localparam int PIX_W  = 16;
  localparam int SUM_W  = 40;
  localparam int SQ_W   = 56;
  localparam int CNT_W  = 25;
  localparam int MEAN_W = 24;
  localparam int SD_W   = 24;

  // shared arithmetic unit and its working registers
  localparam int ALU_W  = 80;
  localparam int DVD_W  = 96;
  localparam int DVS_W  = 50;
  localparam int ROOT_W = 32;
  localparam int ITER_W = 7;

  // iteration counts of the sequencer
  localparam int MDIV_STEPS = 48;
  localparam int DIV_STEPS  = 96;
  localparam int SQRT_STEPS = 32;

  // running accumulators
  typedef struct packed {
    logic signed [PIX_W-1:0] min_v;
    logic signed [PIX_W-1:0] max_v;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sumsq;
    logic [CNT_W-1:0]        count;
  } imms_stats_t;

  // one result transaction
  typedef struct packed {
    logic signed [PIX_W-1:0]  min_value;
    logic signed [PIX_W-1:0]  max_value;
    logic signed [MEAN_W-1:0] mean_q8;
    logic [SD_W-1:0]          stddev_q8;
    logic [CNT_W-1:0]         pixel_count;
    logic                     too_few;
  } imms_res_t;

  // adder control: subtract inverts b, cin is the raw carry-in
  typedef struct packed {
    logic sub;
    logic cin;
  } alu_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/imms_if.sv =====
// valid/ready channel interfaces for pixels and results
`default_nettype none

interface imms_in_if import imms_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel;
  logic                    last;

  modport source (output valid, output pixel, output last, input ready);
  modport sink (input valid, input pixel, input last, output ready);
endinterface

interface imms_out_if import imms_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [PIX_W-1:0]  min_value;
  logic signed [PIX_W-1:0]  max_value;
  logic signed [MEAN_W-1:0] mean_q8;
  logic [SD_W-1:0]          stddev_q8;
  logic [CNT_W-1:0]         pixel_count;
  logic                     too_few;

  modport source (output valid, output min_value, output max_value, output mean_q8,
                  output stddev_q8, output pixel_count, output too_few, input ready);
  modport sink (input valid, input min_value, input max_value, input mean_q8,
                input stddev_q8, input pixel_count, input too_few, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/imms_accum.sv =====
// running min, max, sum, sum of squares and count
`default_nettype none

module imms_accum import imms_pkg::*; #(
  parameter int PIXEL_BITS      = 16,
  parameter int MAX_PIXELS_LOG2 = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic              clear,
  input  logic [PIX_W-1:0]  pixel,
  output imms_stats_t       stats
);

  localparam int SH = PIX_W - PIXEL_BITS;
  localparam logic signed [PIX_W-1:0] MIN_RST = PIX_W'(2**(PIXEL_BITS-1) - 1);
  localparam logic signed [PIX_W-1:0] MAX_RST = PIX_W'(-(2**(PIXEL_BITS-1)));

  logic [PIX_W-1:0]          pix_shl;
  logic signed [PIX_W-1:0]   pix_s;
  logic signed [2*PIX_W-1:0] pix_sq;
  logic                      room;

  logic signed [PIX_W-1:0] min_r;
  logic signed [PIX_W-1:0] max_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0]         sq_r;
  logic [CNT_W-1:0]        cnt_r;

  // keep the low pixel bits as a two's complement value
  assign pix_shl = pixel << SH;
  assign pix_s   = $signed(pix_shl) >>> SH;
  assign pix_sq  = pix_s * pix_s;

  // count never passes the bound, so its bound bit marks a full image
  assign room = ~cnt_r[MAX_PIXELS_LOG2];

  // accumulate one pixel, or return to the empty state
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      min_r <= MIN_RST;
      max_r <= MAX_RST;
      sum_r <= '0;
      sq_r  <= '0;
      cnt_r <= '0;
    end else if (take && room) begin
      if (pix_s < min_r) min_r <= pix_s;
      if (pix_s > max_r) max_r <= pix_s;
      sum_r <= sum_r + SUM_W'(pix_s);
      sq_r  <= sq_r + SQ_W'($unsigned(pix_sq));
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  assign stats.min_v = min_r;
  assign stats.max_v = max_r;
  assign stats.sum   = sum_r;
  assign stats.sumsq = sq_r;
  assign stats.count = cnt_r;

endmodule

`default_nettype wire

// ===== rtl/core/imms_alu.sv =====
// shared 80-bit add/subtract unit with carry out
`default_nettype none

module imms_alu import imms_pkg::*; (
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  input  alu_ctl_t         ctl,
  output logic [ALU_W-1:0] y,
  output logic             cout
);

  logic [ALU_W-1:0] b_sel;
  logic [ALU_W:0]   sum_w;

  // on subtract, cout high means no borrow
  assign b_sel = ctl.sub ? ~b : b;
  assign sum_w = {1'b0, a} + {1'b0, b_sel} + {{ALU_W{1'b0}}, ctl.cin};
  assign y     = sum_w[ALU_W-1:0];
  assign cout  = sum_w[ALU_W];

endmodule

`default_nettype wire

// ===== rtl/core/imms_seq.sv =====
// sequencer for mean, deviation products, division and square root
`default_nettype none
`include "image_min_max_mean_stddev_unit_defines.svh"

module imms_seq import imms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        res_take,
  input  imms_stats_t stats,
  output logic        idle,
  output logic        res_valid,
  output imms_res_t   res
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_MDIV, S_MFIX, S_MUL1, S_MUL2, S_DIFF, S_MUL3, S_DIV, S_SQRT, S_DONE
  } state_t;

  state_t            state_r;
  logic [ITER_W-1:0] cnt_r;
  logic [ALU_W-1:0]  acc_r;
  logic [ALU_W-1:0]  mcd_r;
  logic [SUM_W-1:0]  mlr_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [SUM_W-1:0]  abs_r;
  logic [MEAN_W-1:0] mean_r;
  logic [ROOT_W-1:0] root_r;

  logic [ALU_W-1:0]  div_trial;
  logic [ALU_W-1:0]  sqrt_trial;
  logic [ALU_W-1:0]  sum_ext;
  logic [ALU_W-1:0]  quo_ext;
  logic [ALU_W-1:0]  alu_a;
  logic [ALU_W-1:0]  alu_b;
  logic [ALU_W-1:0]  alu_y;
  alu_ctl_t          alu_ctl;
  logic              alu_cout;
  logic              neg;
  logic              rnz;
  logic              last_step;
  logic              few;
  logic [CNT_W-1:0]  n_m1;

  assign div_trial  = {acc_r[ALU_W-2:0], dvd_r[DVD_W-1]};
  assign sqrt_trial = {acc_r[ALU_W-3:0], dvd_r[2*ROOT_W-1 -: 2]};
  assign sum_ext    = ALU_W'(stats.sum);
  assign quo_ext    = ALU_W'(dvd_r[MDIV_STEPS-1:0]);
  assign neg        = stats.sum[SUM_W-1];
  assign rnz        = |acc_r;
  assign last_step  = (cnt_r == ITER_W'(1));
  assign few        = (stats.count[CNT_W-1:1] == '0);
  assign n_m1       = stats.count - CNT_W'(1);

  // operand selection for the shared unit
  always_comb begin
    alu_a   = acc_r;
    alu_b   = '0;
    alu_ctl = '{sub: 1'b0, cin: 1'b0};
    unique case (state_r)
      S_LOAD: begin
        alu_a   = '0;
        alu_b   = sum_ext;
        alu_ctl = '{sub: neg, cin: neg};
      end
      S_MDIV, S_DIV: begin
        alu_a   = div_trial;
        alu_b   = ALU_W'(dvs_r);
        alu_ctl = '{sub: 1'b1, cin: 1'b1};
      end
      S_MFIX: begin
        // floor for a negative mean: -q, less one when the remainder is nonzero
        alu_a   = neg ? '0 : quo_ext;
        alu_b   = neg ? quo_ext : '0;
        alu_ctl = '{sub: neg, cin: neg & ~rnz};
      end
      S_MUL1, S_MUL2, S_MUL3: begin
        alu_b   = mlr_r[0] ? mcd_r : '0;
      end
      S_DIFF: begin
        alu_a   = dvd_r[ALU_W-1:0];
        alu_b   = acc_r;
        alu_ctl = '{sub: 1'b1, cin: 1'b1};
      end
      S_SQRT: begin
        alu_a   = sqrt_trial;
        alu_b   = ALU_W'({root_r, 2'b01});
        alu_ctl = '{sub: 1'b1, cin: 1'b1};
      end
      default: begin
        alu_a = acc_r;
      end
    endcase
  end

  imms_alu u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .ctl  (alu_ctl),
    .y    (alu_y),
    .cout (alu_cout)
  );

  // sequencer and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) state_r <= S_LOAD;
        end
        S_LOAD: begin
          // |sum|*256 sits in the top 48 bits of the dividend
          abs_r   <= alu_y[SUM_W-1:0];
          dvd_r   <= {alu_y[SUM_W-1:0], (DVD_W-SUM_W)'(0)};
          dvs_r   <= DVS_W'(stats.count);
          acc_r   <= '0;
          cnt_r   <= ITER_W'(MDIV_STEPS);
          state_r <= S_MDIV;
        end
        S_MDIV, S_DIV: begin
          // restoring division, one quotient bit per cycle
          acc_r <= alu_cout ? alu_y : div_trial;
          dvd_r <= {dvd_r[DVD_W-2:0], alu_cout};
          cnt_r <= cnt_r - ITER_W'(1);
          if (last_step) begin
            if (state_r == S_MDIV) begin
              state_r <= S_MFIX;
            end else begin
              acc_r   <= '0;
              root_r  <= '0;
              cnt_r   <= ITER_W'(SQRT_STEPS);
              state_r <= S_SQRT;
            end
          end
        end
        S_MFIX: begin
          mean_r <= alu_y[MEAN_W-1:0];
          if (few) begin
            root_r  <= '0;
            state_r <= S_DONE;
          end else begin
            acc_r   <= '0;
            mcd_r   <= ALU_W'(stats.sumsq);
            mlr_r   <= SUM_W'(stats.count);
            cnt_r   <= ITER_W'(CNT_W);
            state_r <= S_MUL1;
          end
        end
        S_MUL1, S_MUL2, S_MUL3: begin
          // shift-add multiply, one multiplier bit per cycle
          acc_r <= alu_y;
          mcd_r <= {mcd_r[ALU_W-2:0], 1'b0};
          mlr_r <= {1'b0, mlr_r[SUM_W-1:1]};
          cnt_r <= cnt_r - ITER_W'(1);
          if (last_step) begin
            priority case (state_r)
              S_MUL1: begin
                dvd_r   <= DVD_W'(alu_y);
                acc_r   <= '0;
                mcd_r   <= ALU_W'(abs_r);
                mlr_r   <= abs_r;
                cnt_r   <= ITER_W'(SUM_W);
                state_r <= S_MUL2;
              end
              S_MUL2: begin
                state_r <= S_DIFF;
              end
              default: begin
                dvs_r   <= alu_y[DVS_W-1:0];
                acc_r   <= '0;
                cnt_r   <= ITER_W'(DIV_STEPS);
                state_r <= S_DIV;
              end
            endcase
          end
        end
        S_DIFF: begin
          // n*sumsq - sum^2, scaled by 65536
          dvd_r   <= {alu_y, (DVD_W-ALU_W)'(0)};
          acc_r   <= '0;
          mcd_r   <= ALU_W'(stats.count);
          mlr_r   <= SUM_W'(n_m1);
          cnt_r   <= ITER_W'(CNT_W);
          state_r <= S_MUL3;
        end
        S_SQRT: begin
          // digit-by-digit root, two radicand bits per cycle
          acc_r  <= alu_cout ? alu_y : sqrt_trial;
          root_r <= {root_r[ROOT_W-2:0], alu_cout};
          dvd_r  <= {dvd_r[DVD_W-3:0], 2'b00};
          cnt_r  <= cnt_r - ITER_W'(1);
          if (last_step) state_r <= S_DONE;
        end
        S_DONE: begin
          if (res_take) state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // result assembly
  assign idle            = (state_r == S_IDLE);
  assign res_valid       = (state_r == S_DONE);
  assign res.min_value   = stats.min_v;
  assign res.max_value   = stats.max_v;
  assign res.mean_q8     = mean_r;
  assign res.stddev_q8   = (|root_r[ROOT_W-1:SD_W]) ? '1 : root_r[SD_W-1:0];
  assign res.pixel_count = stats.count;
  assign res.too_few     = few;

  `IMMS_ASSERT_NEXT(a_start_load, state_r == S_IDLE && start, state_r == S_LOAD, "last pixel did not start the sequence")
  `IMMS_ASSERT_NOW(a_rem_below_dvs, state_r == S_MDIV || state_r == S_DIV, acc_r < ALU_W'(dvs_r), "division remainder not below divisor")
  `IMMS_ASSERT_NOW(a_diff_nonneg, state_r == S_DIFF, alu_cout, "n*sumsq below sum squared")
  `IMMS_ASSERT_NOW(a_root_fits, state_r == S_DONE && !few, root_r[ROOT_W-1:SD_W] == '0, "deviation root wider than output")

endmodule

`default_nettype wire

// ===== rtl/core/image_min_max_mean_stddev_unit.sv =====
// Image statistics unit: takes one signed pixel per cycle on in_ch and keeps the
// running minimum, maximum, count, sum and sum of squares; the pixel with last set
// closes the image. The unit then drops ready while one shared 80-bit adder works
// through the mean division (48 steps), the products n*sumsq and sum^2 (25 and 40
// steps), the divisor n*(n-1) (25 steps), the 96-step division and the 32-step
// square root, plus the setup states LOAD, MFIX and DIFF. With fewer than two
// pixels only the mean division runs. Ready also stays low while the output
// register still holds an earlier result that out_ch has not taken. The result
// goes into an output register, the accumulators clear, and pixels are taken
// again the next cycle even if out_ch has not yet taken the result. Pixels past
// 2**MAX_PIXELS_LOG2 are ignored. No clearing pass after reset.
`default_nettype none

module image_min_max_mean_stddev_unit import imms_pkg::*; #(
  parameter int PIXEL_BITS      = 16,
  parameter int MAX_PIXELS_LOG2 = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  imms_in_if.sink    in_ch,
  imms_out_if.source out_ch
);

  imms_stats_t stats;
  imms_res_t   res;
  imms_res_t   out_res_r;
  logic        out_valid_r;
  logic        idle;
  logic        res_valid;
  logic        res_take;
  logic        take;
  logic        start;

  // input transaction
  assign in_ch.ready = idle;
  assign take        = in_ch.valid & idle;
  assign start       = take & in_ch.last;

  // result moves to the output register when it is free or being drained
  assign res_take = res_valid & (~out_valid_r | out_ch.ready);

  imms_accum #(
    .PIXEL_BITS      (PIXEL_BITS),
    .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2)
  ) u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .clear (res_take),
    .pixel (in_ch.pixel),
    .stats (stats)
  );

  imms_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .res_take  (res_take),
    .stats     (stats),
    .idle      (idle),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (res_take) out_res_r <= res;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.min_value   = out_res_r.min_value;
  assign out_ch.max_value   = out_res_r.max_value;
  assign out_ch.mean_q8     = out_res_r.mean_q8;
  assign out_ch.stddev_q8   = out_res_r.stddev_q8;
  assign out_ch.pixel_count = out_res_r.pixel_count;
  assign out_ch.too_few     = out_res_r.too_few;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// self-checking testbench for the image statistics unit: pixel driver, result monitor, predictor
`default_nettype none

module tb_top;
  import imms_pkg::*;

  localparam int PIXEL_BITS      = 16;
  localparam int MAX_PIXELS_LOG2 = 24;
  localparam logic [CNT_W-1:0] PIX_LIMIT = CNT_W'(1) << MAX_PIXELS_LOG2;

  // pixel styles of the random images
  typedef enum int {STYLE_FULL, STYLE_NEAR, STYLE_EXTREME, STYLE_FLAT} img_style_t;

  typedef struct {
    logic signed [PIX_W-1:0] pixel;
    logic                    last;
    bit                      drain_first;
  } pixel_item_t;

  logic clk;
  logic rst_n;

  imms_in_if  in_ch ();
  imms_out_if out_ch ();

  image_min_max_mean_stddev_unit #(
    .PIXEL_BITS      (PIXEL_BITS),
    .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pixel_item_t pixel_q[$];
  imms_res_t   image_stats_q[$];

  // running statistics of the image in progress
  logic signed [PIX_W-1:0] lo_pix;
  logic signed [PIX_W-1:0] hi_pix;
  logic signed [SUM_W-1:0] pix_sum;
  logic [SQ_W-1:0]         pix_sq_sum;
  logic [CNT_W-1:0]        pix_cnt;

  int pix_taken;
  int pix_shown;
  int send_gap;
  int recv_stall;
  int fail_count;
  int images_checked;
  int single_images;
  int pixels_sent;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("image_min_max_mean_stddev_unit regression: fail");
    $finish;
  end

  task automatic clear_image();
    lo_pix     = {1'b0, {(PIX_W-1){1'b1}}};
    hi_pix     = {1'b1, {(PIX_W-1){1'b0}}};
    pix_sum    = '0;
    pix_sq_sum = '0;
    pix_cnt    = '0;
  endtask

  // bit-serial integer square root, floor
  function automatic logic [31:0] floor_sqrt(input logic [63:0] x);
    logic [32:0] root;
    logic [32:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (33'd1 << b);
      if (66'(trial) * 66'(trial) <= 66'(x)) root = trial;
    end
    return root[31:0];
  endfunction

  // fold one pixel into the image; on the last pixel queue the image statistics
  task automatic accumulate_pixel(input logic signed [PIX_W-1:0] p, input logic last);
    longint      sq;
    longint      n;
    longint      num;
    longint      mean;
    logic [63:0] usum;
    logic [127:0] spread;
    logic [127:0] quo;
    logic [63:0] var_q;
    logic [31:0] root;
    imms_res_t   stats;
    if (pix_cnt < PIX_LIMIT) begin
      if (p < lo_pix) lo_pix = p;
      if (p > hi_pix) hi_pix = p;
      pix_sum = pix_sum + SUM_W'(p);
      sq = longint'(p) * longint'(p);
      pix_sq_sum = pix_sq_sum + sq[SQ_W-1:0];
      pix_cnt = pix_cnt + 1'b1;
    end
    if (last) begin
      n = longint'(pix_cnt);
      num = longint'(pix_sum) * 64'sd256;
      mean = num / n;
      // round toward minus infinity
      if ((num % n) != 0 && num < 0) mean = mean - 1;
      stats.min_value   = lo_pix;
      stats.max_value   = hi_pix;
      stats.mean_q8     = mean[MEAN_W-1:0];
      stats.pixel_count = pix_cnt;
      stats.too_few     = (pix_cnt < 2);
      stats.stddev_q8   = '0;
      if (!stats.too_few) begin
        usum = (pix_sum < 0) ? 64'(-longint'(pix_sum)) : 64'(longint'(pix_sum));
        spread = 128'(pix_cnt) * 128'(pix_sq_sum) - 128'(usum) * 128'(usum);
        spread = spread << 16;
        quo = spread / (128'(pix_cnt) * 128'(pix_cnt - 1'b1));
        var_q = (quo[127:64] != 0) ? {64{1'b1}} : quo[63:0];
        root = floor_sqrt(var_q);
        stats.stddev_q8 = (root > 32'hFF_FFFF) ? {SD_W{1'b1}} : root[SD_W-1:0];
      end
      image_stats_q.push_back(stats);
      clear_image();
    end
  endtask

  task automatic compare_stats(input imms_res_t got);
    imms_res_t want;
    if (image_stats_q.size() == 0) begin
      $error("unexpected result transaction: min %0d max %0d count %0d",
             got.min_value, got.max_value, got.pixel_count);
      fail_count++;
    end else begin
      want = image_stats_q.pop_front();
      images_checked++;
      if (want.too_few) single_images++;
      if (got.min_value !== want.min_value) begin
        $error("min_value: expected %0d, got %0d", want.min_value, got.min_value);
        fail_count++;
      end
      if (got.max_value !== want.max_value) begin
        $error("max_value: expected %0d, got %0d", want.max_value, got.max_value);
        fail_count++;
      end
      if (got.mean_q8 !== want.mean_q8) begin
        $error("mean_q8: expected %0d, got %0d", want.mean_q8, got.mean_q8);
        fail_count++;
      end
      if (got.stddev_q8 !== want.stddev_q8) begin
        $error("stddev_q8: expected %0d, got %0d", want.stddev_q8, got.stddev_q8);
        fail_count++;
      end
      if (got.pixel_count !== want.pixel_count) begin
        $error("pixel_count: expected %0d, got %0d", want.pixel_count, got.pixel_count);
        fail_count++;
      end
      if (got.too_few !== want.too_few) begin
        $error("too_few: expected %0d, got %0d", want.too_few, got.too_few);
        fail_count++;
      end
    end
  endtask

  // idling allowed outside the tail and outside the quiet windows
  function automatic bit may_idle();
    return pixel_q.size() >= 60 && ((pixel_q.size() / 64) % 3) != 1;
  endfunction

  task automatic push_pixel(input logic signed [PIX_W-1:0] p, input logic last,
                            input bit drain);
    pixel_item_t it;
    it.pixel       = p;
    it.last        = last;
    it.drain_first = drain;
    pixel_q.push_back(it);
  endtask

  function automatic logic signed [PIX_W-1:0] pick_pixel(input img_style_t style,
                                                          input int centre);
    int v;
    case (style)
      STYLE_FULL: begin
        v = $urandom_range(0, 65535) - 32768;
      end
      STYLE_NEAR: begin
        v = centre + $urandom_range(0, 40) - 20;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
      end
      STYLE_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = 0;
          default: v = -1;
        endcase
      end
      default: begin
        v = centre;
      end
    endcase
    return v[PIX_W-1:0];
  endfunction

  // pixel driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && pix_taken != pix_shown) begin
      // transaction still pending, hold it
    end else if (send_gap > 0) begin
      send_gap = send_gap - 1;
      in_ch.valid <= 1'b0;
    end else if (pixel_q.size() == 0) begin
      in_ch.valid <= 1'b0;
    end else if (pixel_q[0].drain_first && image_stats_q.size() != 0) begin
      in_ch.valid <= 1'b0;
    end else if (may_idle() && $urandom_range(0, 7) == 0) begin
      send_gap = $urandom_range(0, 8);
      in_ch.valid <= 1'b0;
    end else begin
      in_ch.valid <= 1'b1;
      in_ch.pixel <= pixel_q[0].pixel;
      in_ch.last  <= pixel_q[0].last;
      pix_shown = pix_taken + 1;
    end
  end

  // result receiver backpressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall = recv_stall - 1;
      out_ch.ready <= 1'b0;
    end else if (may_idle() && $urandom_range(0, 5) == 0) begin
      recv_stall = $urandom_range(0, 8);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor: accepted pixels feed the predictor, accepted results are checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        accumulate_pixel(in_ch.pixel, in_ch.last);
        void'(pixel_q.pop_front());
        pix_taken = pix_taken + 1;
        pixels_sent++;
      end
      if (out_ch.valid && out_ch.ready) begin
        compare_stats('{min_value:   out_ch.min_value,
                        max_value:   out_ch.max_value,
                        mean_q8:     out_ch.mean_q8,
                        stddev_q8:   out_ch.stddev_q8,
                        pixel_count: out_ch.pixel_count,
                        too_few:     out_ch.too_few});
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int         len;
    int         r;
    int         centre;
    int         img_no;
    img_style_t style;
    in_ch.valid  = 1'b0;
    in_ch.pixel  = '0;
    in_ch.last   = 1'b0;
    out_ch.ready = 1'b0;
    rst_n        = 1'b0;
    pix_taken    = 0;
    pix_shown    = 0;
    send_gap     = 0;
    recv_stall   = 0;
    fail_count   = 0;
    images_checked = 0;
    single_images  = 0;
    pixels_sent    = 0;
    clear_image();

    // single pixel images at both extremes
    push_pixel(16'sh7FFF, 1'b1, 1'b0);
    push_pixel(-16'sh8000, 1'b1, 1'b0);
    // widest spread
    push_pixel(-16'sh8000, 1'b0, 1'b0);
    push_pixel(16'sh7FFF, 1'b1, 1'b0);
    // negative mean with remainder
    push_pixel(-16'sd1, 1'b0, 1'b0);
    push_pixel(-16'sd1, 1'b0, 1'b0);
    push_pixel(16'sd0, 1'b1, 1'b0);
    // flat images, zero deviation
    for (int k = 0; k < 4; k++) push_pixel(16'sh7FFF, k == 3, 1'b0);
    for (int k = 0; k < 4; k++) push_pixel(-16'sh8000, k == 3, 1'b0);
    // small ramp and a mixed-sign image
    for (int k = 0; k < 5; k++) push_pixel(PIX_W'(k), k == 4, 1'b0);
    push_pixel(-16'sd5, 1'b0, 1'b0);
    push_pixel(16'sd7, 1'b0, 1'b0);
    push_pixel(-16'sd9, 1'b1, 1'b0);

    // random images, mostly short, a few long
    img_no = 0;
    while (pixel_q.size() < 700) begin
      r = $urandom_range(0, 99);
      if (r < 15) len = 1;
      else if (r < 82) len = $urandom_range(2, 12);
      else if (r < 97) len = $urandom_range(13, 40);
      else len = $urandom_range(100, 250);
      style  = img_style_t'($urandom_range(0, 3));
      centre = $urandom_range(0, 65535) - 32768;
      for (int k = 0; k < len; k++) begin
        push_pixel(pick_pixel(style, centre), k == len - 1, (img_no % 8 == 1) && k == 0);
      end
      img_no++;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (pixel_q.size() == 0);
    for (int k = 0; k < 5000 && image_stats_q.size() != 0; k++) @(posedge clk);
    repeat (300) @(posedge clk);
    if (image_stats_q.size() != 0) begin
      $error("%0d expected results never arrived", image_stats_q.size());
      fail_count++;
    end

    $display("checked %0d images (%0d with a single pixel) over %0d pixels,",
             images_checked, single_images, pixels_sent);
    $display("with random gaps on both channels and a drain pause before some images");
    if (fail_count == 0) begin
      $display("image_min_max_mean_stddev_unit regression: pass");
    end else begin
      $display("image_min_max_mean_stddev_unit regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/imms_pkg.sv
rtl/core/imms_if.sv
rtl/core/imms_accum.sv
rtl/core/imms_alu.sv
rtl/core/imms_seq.sv
rtl/core/image_min_max_mean_stddev_unit.sv
verif/tb_top.sv
